@@ rtl/qakb_pkg.sv @@
// Shared types and constants for the quota admission keyed buffer.
`timescale 1ns / 1ps

package qakb_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int CNT_W            = 7;
   localparam int BYTES_W          = 24;
   localparam int HELD_W           = 28;
   localparam int CSR_IDX_W        = 2;

   typedef enum logic [2:0] {
      OP_INSERT      = 3'd0,
      OP_LOOKUP      = 3'd1,
      OP_ERASE       = 3'd2,
      OP_DRAIN       = 3'd3,
      OP_PURGE_CFG   = 3'd4,
      OP_PURGE_EPOCH = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ENTRIES        = 2'd0,
      CSR_MAX_TOTAL_BYTES    = 2'd1,
      CSR_MAX_BUCKET_ENTRIES = 2'd2,
      CSR_MAX_BUCKET_BYTES   = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } fsm_type;

   typedef struct packed {
      logic [31:0]        epoch;
      logic [31:0]        config_tag;
      logic [63:0]        block_tag;
      logic [31:0]        generation;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

   // Broadcast control for the row of cells.
   typedef struct packed {
      logic             step;
      logic             keep;
      logic [CNT_W-1:0] live;
      logic             ins_en;
      logic [CNT_W-1:0] ins_idx;
   } cell_ctl_type;

endpackage

@@ rtl/qakb_cell.sv @@
// One table slot of the rotating entry chain.
`timescale 1ns / 1ps

module qakb_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  qakb_pkg::cell_ctl_type ctl,
   input  qakb_pkg::entry_type   shift_d,
   input  qakb_pkg::entry_type   head_d,
   input  qakb_pkg::entry_type   new_d,
   output qakb_pkg::entry_type   entry_q
);

   qakb_pkg::entry_type entry_ff, entry_in;

   // A kept head entry re-enters at the tail of the live region.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en && ctl.ins_idx == qakb_pkg::CNT_W'(IDX)) begin
         entry_in = new_d;
      end else if (ctl.step) begin
         if (ctl.keep && ctl.live == qakb_pkg::CNT_W'(IDX + 1)) begin
            entry_in = head_d;
         end else begin
            entry_in = shift_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

@@ rtl/quota_admission_keyed_buffer.sv @@
// Top level of the quota admission keyed buffer: control and the cell row.
`timescale 1ns / 1ps

// The request channel (req_*) carries one operation per beat: insert, lookup,
// erase, drain of a configuration, purge of a configuration, or purge of all
// entries before an epoch. The response channel (rsp_*) returns one beat per
// operation, except a drain that finds entries, which returns one beat per
// drained entry in table order, the final one flagged by rsp_last. Unknown
// op codes are accepted and dropped without a response.
// The table is a row of CAPACITY cells that, during a scan, shifts toward cell
// 0 one step a cycle unless a drained entry waits on a stalled output; the head
// entry is inspected and either re-enters at the tail of the live region or is
// dropped, which compacts the table in order.
// An operation passes through an accept in the idle state, a rotation of every
// stored entry through cell 0 that a closing check ends, and a finish state
// that loads the response. A drain that finds entries rotates twice: it first
// counts matches and then removes them.
// New requests are taken only when the previous one is done, but a finished
// response may still wait in the output register while the next is accepted.
// Reset empties the table and loads the default limits; the slot contents
// are not cleared. When the receiver stalls, the output register holds its
// beat and the rotation pauses before it would produce another one.
// The csr_* port writes the four limits at any idle time, with no wait.

module quota_admission_keyed_buffer #(
   parameter int CAPACITY = qakb_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_op,
   input  logic [31:0]                   req_epoch,
   input  logic [31:0]                   req_config_tag,
   input  logic [63:0]                   req_block_tag,
   input  logic [31:0]                   req_generation,
   input  logic [qakb_pkg::BYTES_W-1:0]  req_payload_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [qakb_pkg::CNT_W-1:0]    rsp_removed_count,
   output logic                          rsp_entry_valid,
   output logic [31:0]                   rsp_entry_epoch,
   output logic [63:0]                   rsp_entry_block_tag,
   output logic [31:0]                   rsp_entry_generation,
   output logic [qakb_pkg::BYTES_W-1:0]  rsp_entry_bytes,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [qakb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qakb_pkg::HELD_W-1:0]   csr_wdata
);

   localparam int OW  = $clog2(CAPACITY + 1);
   localparam int BBW = qakb_pkg::BYTES_W + OW;
   localparam int CW  = qakb_pkg::CNT_W;
   localparam int HW  = qakb_pkg::HELD_W;

   // Configuration registers.
   logic [CW-1:0] max_entries_ff, max_bucket_entries_ff;
   logic [HW-1:0] max_total_bytes_ff, max_bucket_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff        <= CW'(16);
         max_total_bytes_ff    <= '1;
         max_bucket_entries_ff <= CW'(16);
         max_bucket_bytes_ff   <= '1;
      end else if (csr_we) begin
         unique case (qakb_pkg::csr_idx_type'(csr_index))
            qakb_pkg::CSR_MAX_ENTRIES:        max_entries_ff <= csr_wdata[CW-1:0];
            qakb_pkg::CSR_MAX_TOTAL_BYTES:    max_total_bytes_ff <= csr_wdata;
            qakb_pkg::CSR_MAX_BUCKET_ENTRIES: max_bucket_entries_ff <= csr_wdata[CW-1:0];
            qakb_pkg::CSR_MAX_BUCKET_BYTES:   max_bucket_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control state.
   qakb_pkg::fsm_type state_ff, state_in;
   logic [OW-1:0]  occ_ff, occ_in, live_ff, live_in, cnt_ff, cnt_in;
   logic [OW-1:0]  nrm_ff, nrm_in, total_ff, total_in, bcnt_ff, bcnt_in;
   logic [BBW-1:0] bbytes_ff, bbytes_in;
   logic [HW-1:0]  held_ff, held_in;
   logic           match_ff, match_in, pass2_ff, pass2_in;

   // Latched request.
   logic [2:0]                   op_ff, op_in;
   qakb_pkg::entry_type          req_ff, req_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   status_ff, status_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         ev_ff, ev_in, last_ff, last_in;
   qakb_pkg::entry_type          rent_ff, rent_in;

   // Cell row.
   qakb_pkg::entry_type          cell_q [CAPACITY];
   qakb_pkg::entry_type          head;
   qakb_pkg::cell_ctl_type       ctl;

   logic step, keep, ins_en;
   logic key_hit, cfg_hit, bkt_hit, old_hit, remove, emit_need, out_free;
   logic [CW-1:0] lim_e;
   logic reject;

   assign head = cell_q[0];

   assign cfg_hit = head.epoch == req_ff.epoch && head.config_tag == req_ff.config_tag;
   assign key_hit = cfg_hit && head.block_tag == req_ff.block_tag;
   assign bkt_hit = cfg_hit && head.generation == req_ff.generation;
   assign old_hit = head.epoch < req_ff.epoch;

   always_comb begin
      unique case (op_ff)
         qakb_pkg::OP_ERASE:       remove = key_hit && !match_ff;
         qakb_pkg::OP_DRAIN:       remove = pass2_ff && cfg_hit;
         qakb_pkg::OP_PURGE_CFG:   remove = cfg_hit;
         qakb_pkg::OP_PURGE_EPOCH: remove = old_hit;
         default:                  remove = 1'b0;
      endcase
   end

   assign emit_need = op_ff == qakb_pkg::OP_DRAIN && pass2_ff && cfg_hit;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Admission: an entry limit fails if the current count is at or above it; a byte
   // limit fails if current or current plus the addition is above it. A full table also rejects.
   always_comb begin
      lim_e  = (max_entries_ff > CW'(CAPACITY)) ? CW'(CAPACITY) : max_entries_ff;
      reject = (CW'(occ_ff) >= lim_e)
            || (held_ff > max_total_bytes_ff)
            || ((32'(held_ff) + 32'(req_ff.bytes)) > 32'(max_total_bytes_ff))
            || (CW'(bcnt_ff) >= max_bucket_entries_ff)
            || (32'(bbytes_ff) > 32'(max_bucket_bytes_ff))
            || ((32'(bbytes_ff) + 32'(req_ff.bytes)) > 32'(max_bucket_bytes_ff))
            || (occ_ff >= OW'(CAPACITY));
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      live_in      = live_ff;
      cnt_in       = cnt_ff;
      nrm_in       = nrm_ff;
      total_in     = total_ff;
      bcnt_in      = bcnt_ff;
      bbytes_in    = bbytes_ff;
      held_in      = held_ff;
      match_in     = match_ff;
      pass2_in     = pass2_ff;
      op_in        = op_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      count_in     = count_ff;
      ev_in        = ev_ff;
      last_in      = last_ff;
      rent_in      = rent_ff;
      step         = 1'b0;
      keep         = 1'b1;
      ins_en       = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         qakb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in             = req_op;
               req_in.epoch      = req_epoch;
               req_in.config_tag = req_config_tag;
               req_in.block_tag  = req_block_tag;
               req_in.generation = req_generation;
               req_in.bytes      = req_payload_bytes;
               cnt_in    = '0;
               live_in   = occ_ff;
               nrm_in    = '0;
               total_in  = '0;
               bcnt_in   = '0;
               bbytes_in = '0;
               match_in  = 1'b0;
               pass2_in  = 1'b0;
               if (req_op <= 3'(qakb_pkg::OP_PURGE_EPOCH)) begin
                  state_in = qakb_pkg::S_SCAN;
               end
            end
         end
         qakb_pkg::S_SCAN: begin
            if (cnt_ff == occ_ff) begin
               if (op_ff == qakb_pkg::OP_DRAIN && !pass2_ff && total_ff != '0) begin
                  // Count pass done; run the removal pass.
                  pass2_in = 1'b1;
                  cnt_in   = '0;
               end else begin
                  state_in = qakb_pkg::S_FINISH;
               end
            end else if (!(emit_need && !out_free)) begin
               step   = 1'b1;
               keep   = !remove;
               cnt_in = cnt_ff + OW'(1);
               if (key_hit) begin
                  match_in = 1'b1;
               end
               if (bkt_hit) begin
                  bcnt_in   = bcnt_ff + OW'(1);
                  bbytes_in = bbytes_ff + BBW'(head.bytes);
               end
               if (op_ff == qakb_pkg::OP_DRAIN && !pass2_ff && cfg_hit) begin
                  total_in = total_ff + OW'(1);
               end
               if (remove) begin
                  live_in = live_ff - OW'(1);
                  nrm_in  = nrm_ff + OW'(1);
                  held_in = held_ff - HW'(head.bytes);
               end
               if (emit_need) begin
                  rsp_valid_in = 1'b1;
                  status_in    = 3'(qakb_pkg::ST_FOUND);
                  count_in     = CW'(total_ff);
                  ev_in        = 1'b1;
                  rent_in      = head;
                  last_in      = (nrm_ff + OW'(1)) == total_ff;
               end
            end
         end
         qakb_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = qakb_pkg::S_IDLE;
               occ_in   = live_ff;
               count_in = '0;
               ev_in    = 1'b0;
               rent_in  = '0;
               last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  qakb_pkg::OP_INSERT: begin
                     if (match_ff) begin
                        status_in = 3'(qakb_pkg::ST_DUPLICATE);
                     end else if (reject) begin
                        status_in = 3'(qakb_pkg::ST_REJECTED);
                     end else begin
                        status_in = 3'(qakb_pkg::ST_INSERTED);
                        ins_en    = 1'b1;
                        occ_in    = occ_ff + OW'(1);
                        held_in   = held_ff + HW'(req_ff.bytes);
                     end
                  end
                  qakb_pkg::OP_LOOKUP, qakb_pkg::OP_ERASE: begin
                     status_in = match_ff ? 3'(qakb_pkg::ST_FOUND)
                                          : 3'(qakb_pkg::ST_NOT_FOUND);
                     count_in  = CW'(nrm_ff);
                  end
                  qakb_pkg::OP_DRAIN: begin
                     // Drained entries were already delivered.
                     status_in    = 3'(qakb_pkg::ST_NOT_FOUND);
                     rsp_valid_in = (total_ff == '0) || (rsp_valid_ff && !rsp_ready);
                     if (total_ff != '0) begin
                        status_in = status_ff;
                        count_in  = count_ff;
                        ev_in     = ev_ff;
                        rent_in   = rent_ff;
                        last_in   = last_ff;
                     end
                  end
                  default: begin
                     status_in = (nrm_ff != '0) ? 3'(qakb_pkg::ST_FOUND)
                                                : 3'(qakb_pkg::ST_NOT_FOUND);
                     count_in  = CW'(nrm_ff);
                  end
               endcase
            end
         end
         default: state_in = qakb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qakb_pkg::S_IDLE;
         occ_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         live_ff      <= '0;
         cnt_ff       <= '0;
         nrm_ff       <= '0;
         total_ff     <= '0;
         bcnt_ff      <= '0;
         bbytes_ff    <= '0;
         match_ff     <= 1'b0;
         pass2_ff     <= 1'b0;
         op_ff        <= 3'(qakb_pkg::OP_INSERT);
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
         cnt_ff       <= cnt_in;
         nrm_ff       <= nrm_in;
         total_ff     <= total_in;
         bcnt_ff      <= bcnt_in;
         bbytes_ff    <= bbytes_in;
         match_ff     <= match_in;
         pass2_ff     <= pass2_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      ev_ff     <= ev_in;
      last_ff   <= last_in;
      rent_ff   <= rent_in;
   end

   assign ctl.step    = step;
   assign ctl.keep    = keep;
   assign ctl.live    = CW'(live_ff);
   assign ctl.ins_en  = ins_en;
   assign ctl.ins_idx = CW'(occ_ff);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      qakb_cell #(
         .IDX (g)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .shift_d (cell_q[(g + 1) % CAPACITY]),
         .head_d  (head),
         .new_d   (req_ff),
         .entry_q (cell_q[g])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_count    = count_ff;
   assign rsp_entry_valid      = ev_ff;
   assign rsp_entry_epoch      = rent_ff.epoch;
   assign rsp_entry_block_tag  = rent_ff.block_tag;
   assign rsp_entry_generation = rent_ff.generation;
   assign rsp_entry_bytes      = rent_ff.bytes;
   assign rsp_last             = last_ff;

endmodule
